/* src/rbh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rbh_pkg;

    // Widest value the decoder handles
    localparam int unsigned MAX_BIT_WIDTH = 32;

    // Error codes carried on a result beat
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_EMPTY_PACK = 2'd1;
    localparam logic [1:0] ERR_GROUPS     = 2'd2;
    localparam logic [1:0] ERR_VARINT     = 2'd3;

    // Group counts at or above this are rejected
    localparam logic [33:0] GROUP_LIMIT = 34'd268435455;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] repeat_res;
        logic        is_run;
        logic [1:0]  error_code;
        logic        last_of_input;
    } result_t;

    // Parser to unpacker control
    typedef struct packed {
        logic        clear;
        logic        start;
        logic [31:0] count;
        logic        feed;
        logic [7:0]  data;
    } unp_ctrl_t;

    // Unpacker status back to parser and top
    typedef struct packed {
        logic busy;
        logic done;
    } unp_stat_t;

    // Mask of the low w bits, w in 1..32
    function automatic logic [31:0] width_mask(input logic [5:0] w);
        logic [5:0] sh;
        sh = 6'd32 - w;
        return 32'hFFFF_FFFF >> sh;
    endfunction

endpackage

`default_nettype wire

/* src/rle_bitpack_hybrid_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_data_byte (one stream byte)
// cfg_      in         cfg_valid/cfg_ready cfg_bit_width
// m_        out        m_valid / m_ready   m_value, m_repeat_res, m_is_run,
//                                          m_error_code, m_last_of_input
//
// Header and repeat-value bytes are taken one per cycle, while the output
// buffer has room. A bit-packed byte holds off the next byte while the
// unpack shifter emits one value per cycle, room allowing (up to 8 at bit width 1).
// Reset is synchronous on aresetn low; bit width returns to 1.
// A two-entry output buffer lets a byte be taken while a result beat stalls.

module rle_bitpack_hybrid_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_bit_width,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_value,
    output logic [31:0]      m_repeat_res,
    output logic             m_is_run,
    output logic [1:0]       m_error_code,
    output logic             m_last_of_input
);

    logic [5:0]         bit_width_reg;
    logic [5:0]         width;
    logic               cfg_wr;
    logic               accept;
    logic               full;
    rbh_pkg::unp_ctrl_t unp_ctrl;
    rbh_pkg::unp_stat_t unp_stat;
    logic               p_push, u_push;
    rbh_pkg::result_t   p_result, u_result, push_data, head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_ready   = !unp_stat.busy && !full;
    assign accept    = s_valid && s_ready;

    // Hold the width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_width_reg <= 6'd1;
        end else if (cfg_wr) begin
            bit_width_reg <= cfg_bit_width;
        end
    end

    // Saturate the width into 1..MAX_BIT_WIDTH
    always_comb begin
        if (bit_width_reg == 6'd0) begin
            width = 6'd1;
        end else if (bit_width_reg > 6'(rbh_pkg::MAX_BIT_WIDTH)) begin
            width = 6'(rbh_pkg::MAX_BIT_WIDTH);
        end else begin
            width = bit_width_reg;
        end
    end

    rbh_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .cfg_wr    (cfg_wr),
        .width     (width),
        .unp_stat  (unp_stat),
        .unp_ctrl  (unp_ctrl),
        .push      (p_push),
        .result    (p_result)
    );

    rbh_unpack u_unpack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .unp_ctrl (unp_ctrl),
        .width    (width),
        .space    (!full),
        .unp_stat (unp_stat),
        .push     (u_push),
        .result   (u_result)
    );

    // Parser and unpacker never push in the same cycle
    assign push_data = p_push ? p_result : u_result;

    rbh_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p_push || u_push),
        .push_data (push_data),
        .full      (full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    assign m_value         = head.value;
    assign m_repeat_res    = head.repeat_res;
    assign m_is_run        = head.is_run;
    assign m_error_code    = head.error_code;
    assign m_last_of_input = head.last_of_input;

endmodule

`default_nettype wire

/* src/rbh_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module rbh_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              cfg_wr,
    input  wire logic [5:0]        width,
    input  wire rbh_pkg::unp_stat_t unp_stat,
    output rbh_pkg::unp_ctrl_t     unp_ctrl,
    output logic                   push,
    output rbh_pkg::result_t       result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_PACKED = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [34:0] accum_reg, accum_next;
    logic [2:0]  vbytes_reg, vbytes_next;
    logic [31:0] run_value_reg, run_value_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] rep_reg, rep_next;

    logic [5:0]  vshift;
    logic [34:0] acc_new;
    logic [33:0] cnt;
    logic [2:0]  nbytes;
    logic [31:0] rv_new;
    logic [31:0] mask;

    assign vshift  = {vbytes_reg, 3'b000} - {3'b000, vbytes_reg};
    assign acc_new = accum_reg | ({28'd0, data_byte[6:0]} << vshift);
    assign cnt     = acc_new[34:1];
    assign nbytes  = 3'(({1'b0, width} + 7'd7) >> 3);
    assign rv_new  = run_value_reg | ({24'd0, data_byte} << {idx_reg, 3'b000});
    assign mask    = rbh_pkg::width_mask(width);

    // Decode one header or value byte, or feed a bit-packed byte to the unpacker
    always_comb begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        vbytes_next    = vbytes_reg;
        run_value_next = run_value_reg;
        idx_next       = idx_reg;
        rep_next       = rep_reg;
        push           = 1'b0;
        result         = '0;
        result.last_of_input = 1'b1;
        unp_ctrl       = '0;
        unp_ctrl.data  = data_byte;

        if (cfg_wr) begin
            phase_next     = PH_HEADER;
            accum_next     = '0;
            vbytes_next    = '0;
            run_value_next = '0;
            idx_next       = '0;
            rep_next       = '0;
            unp_ctrl.clear = 1'b1;
        end else begin
            if (accept) begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (data_byte[7]) begin
                            if (vbytes_reg >= 3'd4) begin
                                accum_next        = '0;
                                vbytes_next       = '0;
                                push              = 1'b1;
                                result.error_code = rbh_pkg::ERR_VARINT;
                            end else begin
                                accum_next  = acc_new;
                                vbytes_next = vbytes_reg + 3'd1;
                            end
                        end else begin
                            accum_next  = '0;
                            vbytes_next = '0;
                            if (acc_new[0]) begin
                                if (cnt == 34'd0) begin
                                    push              = 1'b1;
                                    result.error_code = rbh_pkg::ERR_EMPTY_PACK;
                                end else if (cnt >= rbh_pkg::GROUP_LIMIT) begin
                                    push              = 1'b1;
                                    result.error_code = rbh_pkg::ERR_GROUPS;
                                end else begin
                                    unp_ctrl.start = 1'b1;
                                    unp_ctrl.count = {cnt[28:0], 3'b000};
                                    phase_next     = PH_PACKED;
                                end
                            end else begin
                                rep_next       = (|cnt[33:32]) ? 32'hFFFF_FFFF : cnt[31:0];
                                run_value_next = '0;
                                idx_next       = '0;
                                phase_next     = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (({1'b0, idx_reg} + 3'd1) >= nbytes) begin
                            if (rep_reg != 32'd0) begin
                                push              = 1'b1;
                                result.value      = rv_new & mask;
                                result.repeat_res = rep_reg;
                                result.is_run     = 1'b1;
                            end
                            phase_next     = PH_HEADER;
                            run_value_next = '0;
                            idx_next       = '0;
                            rep_next       = '0;
                        end else begin
                            run_value_next = rv_new;
                            idx_next       = idx_reg + 2'd1;
                        end
                    end
                    PH_PACKED: begin
                        unp_ctrl.feed = 1'b1;
                    end
                    default: begin
                        phase_next     = PH_HEADER;
                        accum_next     = '0;
                        vbytes_next    = '0;
                        run_value_next = '0;
                        idx_next       = '0;
                        rep_next       = '0;
                        unp_ctrl.clear = 1'b1;
                    end
                endcase
            end
            // Return to header parsing once the packed run has emitted its last value
            if (unp_stat.done) begin
                phase_next = PH_HEADER;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            accum_reg     <= '0;
            vbytes_reg    <= '0;
            run_value_reg <= '0;
            idx_reg       <= '0;
            rep_reg       <= '0;
        end else begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            vbytes_reg    <= vbytes_next;
            run_value_reg <= run_value_next;
            idx_reg       <= idx_next;
            rep_reg       <= rep_next;
        end
    end

endmodule

`default_nettype wire

/* src/rbh_unpack.sv */
`timescale 1ns / 1ps
`default_nettype none

module rbh_unpack (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rbh_pkg::unp_ctrl_t unp_ctrl,
    input  wire logic [5:0]         width,
    input  wire logic               space,
    output rbh_pkg::unp_stat_t      unp_stat,
    output logic                    push,
    output rbh_pkg::result_t        result
);

    logic [39:0] buf_reg, buf_next;
    logic [5:0]  held_reg, held_next;
    logic [31:0] left_reg, left_next;
    logic        busy_reg, busy_next;

    logic [39:0] merged_buf;
    logic [5:0]  merged_held;
    logic [39:0] shifted_buf;
    logic [5:0]  rest_held;
    logic [31:0] rest_left;
    logic        can_emit;
    logic        more;

    // Append the fed byte above the bits still held
    assign merged_buf  = unp_ctrl.feed ? (buf_reg | ({32'd0, unp_ctrl.data} << held_reg))
                                       : buf_reg;
    assign merged_held = unp_ctrl.feed ? held_reg + 6'd8 : held_reg;
    assign can_emit    = (unp_ctrl.feed || busy_reg) && (merged_held >= width)
                         && (left_reg != 32'd0);
    assign shifted_buf = merged_buf >> width;
    assign rest_held   = merged_held - width;
    assign rest_left   = left_reg - 32'd1;
    assign more        = (rest_held >= width) && (rest_left != 32'd0);

    assign push = can_emit && space;

    always_comb begin
        result               = '0;
        result.value         = merged_buf[31:0] & rbh_pkg::width_mask(width);
        result.repeat_res    = 32'd1;
        result.last_of_input = !more;
    end

    // Advance one value per beat
    always_comb begin
        buf_next      = buf_reg;
        held_next     = held_reg;
        left_next     = left_reg;
        busy_next     = busy_reg;
        unp_stat.busy = busy_reg;
        unp_stat.done = 1'b0;
        if (unp_ctrl.clear) begin
            buf_next  = '0;
            held_next = '0;
            left_next = '0;
            busy_next = 1'b0;
        end else if (unp_ctrl.start) begin
            buf_next  = '0;
            held_next = '0;
            left_next = unp_ctrl.count;
            busy_next = 1'b0;
        end else if (push) begin
            if (rest_left == 32'd0) begin
                buf_next      = '0;
                held_next     = '0;
                left_next     = '0;
                busy_next     = 1'b0;
                unp_stat.done = 1'b1;
            end else begin
                buf_next  = shifted_buf;
                held_next = rest_held;
                left_next = rest_left;
                busy_next = more;
            end
        end else if (unp_ctrl.feed || busy_reg) begin
            buf_next  = merged_buf;
            held_next = merged_held;
            busy_next = can_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            held_reg <= '0;
            left_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
            left_reg <= left_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

/* src/rbh_skid.sv */
`timescale 1ns / 1ps
`default_nettype none

module rbh_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire rbh_pkg::result_t push_data,
    output logic                  full,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output rbh_pkg::result_t      head
);

    logic [1:0]       count_reg, count_next;
    rbh_pkg::result_t head_reg, head_next;
    rbh_pkg::result_t tail_reg, tail_next;
    logic             pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign head    = head_reg;

    // Two-entry output buffer; the tail slot catches a beat while the head stalls
    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case (count_reg)
            2'd0: begin
                if (push) begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1: begin
                if (pop && push) begin
                    head_next = push_data;
                end else if (pop) begin
                    count_next = 2'd0;
                end else if (push) begin
                    tail_next  = push_data;
                    count_next = 2'd2;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next  = tail_reg;
                    count_next = 2'd1;
                end
            end
            default: begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES = 160;
    localparam int unsigned N_PHASES = 8;
    localparam int unsigned N_DIRECTED = 29;
    localparam logic [33:0] MAX_GROUPS = 34'd268435455;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_RUN_VALUE,
        DEC_PACKED
    } dec_phase_e;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [7:0]        data;
        logic              typed;
        rbh_pkg::result_t  exp;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_bit_width = 6'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_value;
    logic [31:0] m_repeat_res;
    logic        m_is_run;
    logic [1:0]  m_error_code;
    logic        m_last_of_input;

    // Decoder state mirror
    logic [5:0]  width_reg;
    dec_phase_e  dec_phase;
    logic [63:0] hdr_accum;
    int unsigned hdr_bytes;
    logic [31:0] run_value;
    int unsigned value_idx;
    logic [31:0] values_left;
    logic [63:0] bit_buf;
    int unsigned bits_held;

    rbh_pkg::result_t expected_q[$];
    rbh_pkg::result_t rx_want;
    int unsigned mismatches = 0;
    int unsigned beats_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned rx_stall = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    stim_row_t   directed_rows[N_DIRECTED];

    rle_bitpack_hybrid_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_bit_width   (cfg_bit_width),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_repeat_res    (m_repeat_res),
        .m_is_run        (m_is_run),
        .m_error_code    (m_error_code),
        .m_last_of_input (m_last_of_input)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Width in effect: zero acts as one, anything past the maximum saturates
    function automatic int unsigned active_width();
        int unsigned cap;
        int unsigned w;
        cap = (rbh_pkg::MAX_BIT_WIDTH > 32) ? 32 : rbh_pkg::MAX_BIT_WIDTH;
        if (cap < 1) cap = 1;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > cap) w = cap;
        return w;
    endfunction

    function automatic void clear_decoder();
        dec_phase = DEC_HEADER;
        hdr_accum = '0;
        hdr_bytes = 0;
        run_value = '0;
        value_idx = 0;
        values_left = '0;
        bit_buf = '0;
        bits_held = 0;
    endfunction

    function automatic rbh_pkg::result_t one_result(input logic [31:0] v,
                                                    input logic [31:0] rep,
                                                    input logic run, input logic [1:0] err);
        rbh_pkg::result_t r;
        r.value = v;
        r.repeat_res = rep;
        r.is_run = run;
        r.error_code = err;
        r.last_of_input = 1'b1;
        return r;
    endfunction

    function automatic void push_result(input logic [31:0] v, input logic [31:0] rep,
                                        input logic run, input logic [1:0] err);
        rbh_pkg::result_t r;
        r = one_result(v, rep, run, err);
        r.last_of_input = 1'b0;
        expected_q.push_back(r);
    endfunction

    // Advance the decoder mirror by one stream byte and queue what it yields
    function automatic void decode_byte(input logic [7:0] b);
        int unsigned w;
        int unsigned n0;
        int unsigned produced;
        logic [31:0] mask;
        logic [63:0] hdr;
        logic [63:0] cnt;
        rbh_pkg::result_t r;
        w = active_width();
        mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        n0 = expected_q.size();
        produced = 0;
        case (dec_phase)
            DEC_HEADER: begin
                hdr_accum |= 64'(b[6:0]) << (7 * hdr_bytes);
                if (b[7]) begin
                    if (hdr_bytes >= 4) begin
                        clear_decoder();
                        push_result('0, '0, 1'b0, rbh_pkg::ERR_VARINT);
                    end else begin
                        hdr_bytes++;
                    end
                end else begin
                    hdr = hdr_accum & 64'h7_FFFF_FFFF;
                    cnt = hdr >> 1;
                    hdr_accum = '0;
                    hdr_bytes = 0;
                    if (hdr[0]) begin
                        if (cnt == 0) begin
                            push_result('0, '0, 1'b0, rbh_pkg::ERR_EMPTY_PACK);
                        end else if (cnt >= 64'(MAX_GROUPS)) begin
                            push_result('0, '0, 1'b0, rbh_pkg::ERR_GROUPS);
                        end else begin
                            values_left = 32'(cnt * 8);
                            bit_buf = '0;
                            bits_held = 0;
                            dec_phase = DEC_PACKED;
                        end
                    end else begin
                        values_left = (cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt[31:0];
                        run_value = '0;
                        value_idx = 0;
                        dec_phase = DEC_RUN_VALUE;
                    end
                end
            end
            DEC_RUN_VALUE: begin
                run_value |= 32'(b) << (8 * value_idx);
                if (value_idx + 1 >= (w + 7) / 8) begin
                    if (values_left != 0)
                        push_result(run_value & mask, values_left, 1'b1, rbh_pkg::ERR_NONE);
                    clear_decoder();
                end else begin
                    value_idx++;
                end
            end
            DEC_PACKED: begin
                bit_buf |= 64'(b) << bits_held;
                bits_held += 8;
                while (bits_held >= w && values_left != 0 && produced < 8) begin
                    push_result(bit_buf[31:0] & mask, 32'd1, 1'b0, rbh_pkg::ERR_NONE);
                    bit_buf >>= w;
                    bits_held -= w;
                    values_left--;
                    produced++;
                end
                bit_buf &= 64'hFF_FFFF_FFFF;
                if (values_left == 0) clear_decoder();
            end
            default: begin
                clear_decoder();
            end
        endcase
        // Flag the final beat caused by this byte
        if (expected_q.size() > n0) begin
            r = expected_q.pop_back();
            r.last_of_input = 1'b1;
            expected_q.push_back(r);
        end
    endfunction

    // Append a header as ULEB128 bytes
    function automatic void add_varint(ref logic [7:0] q[$], input logic [34:0] hdr);
        logic [34:0] rest;
        rest = hdr;
        do begin
            q.push_back({(rest > 35'h7F), rest[6:0]});
            rest >>= 7;
        end while (rest != 0);
    endfunction

    // Hold valid until the beat is taken, then predict; a typed row overrides the prediction
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input rbh_pkg::result_t exp);
        int unsigned gap;
        int unsigned n0;
        if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n0 = expected_q.size();
        decode_byte(b);
        if (typed) begin
            while (expected_q.size() > n0) void'(expected_q.pop_back());
            expected_q.push_back(exp);
        end
        bytes_sent++;
    endtask

    // Drop valid and let every expected beat drain out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [5:0] w);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_bit_width <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = w;
        clear_decoder();
    endtask

    // One run: mostly well-formed repeat or packed runs, some error headers and noise
    task automatic send_run();
        logic [7:0]  run_bytes[$];
        int unsigned pick;
        int unsigned w;
        int unsigned groups_n;
        logic [33:0] count;
        w = active_width();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            case ($urandom_range(0, 9))
                0: count = '0;
                1: count = {2'($urandom_range(0, 3)), 32'($urandom)};
                default: count = 34'($urandom_range(1, 300));
            endcase
            add_varint(run_bytes, {count, 1'b0});
            repeat ((w + 7) / 8) run_bytes.push_back(8'($urandom));
        end else if (pick < 85) begin
            groups_n = (w <= 8) ? $urandom_range(1, 3) : 1;
            add_varint(run_bytes, {34'(groups_n), 1'b1});
            repeat (groups_n * w) run_bytes.push_back(8'($urandom));
        end else begin
            case ($urandom_range(0, 3))
                0: run_bytes.push_back(8'h01);
                1: repeat (5) run_bytes.push_back({1'b1, 7'($urandom)});
                2: begin
                    count = ($urandom_range(0, 1) == 0) ? MAX_GROUPS
                                                         : MAX_GROUPS + 34'($urandom);
                    add_varint(run_bytes, {count, 1'b1});
                end
                default: repeat ($urandom_range(1, 3)) run_bytes.push_back(8'($urandom));
            endcase
        end
        foreach (run_bytes[k]) send_byte(run_bytes[k], 1'b0, '0);
        if ($urandom_range(0, 15) == 0) wait_idle();
    endtask

    // Check each result beat against the oldest expectation; draw the next stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("beat %0d with nothing expected, value %h",
                                              beats_seen, m_value));
                end else begin
                    rx_want = expected_q.pop_front();
                    if (m_value !== rx_want.value)
                        report_mismatch($sformatf("beat %0d value %h, want %h",
                                                  beats_seen, m_value, rx_want.value));
                    if (m_repeat_res !== rx_want.repeat_res)
                        report_mismatch($sformatf("beat %0d repeat %h, want %h",
                                                  beats_seen, m_repeat_res,
                                                  rx_want.repeat_res));
                    if (m_is_run !== rx_want.is_run)
                        report_mismatch($sformatf("beat %0d is_run %b, want %b",
                                                  beats_seen, m_is_run, rx_want.is_run));
                    if (m_error_code !== rx_want.error_code)
                        report_mismatch($sformatf("beat %0d error %0d, want %0d",
                                                  beats_seen, m_error_code,
                                                  rx_want.error_code));
                    if (m_last_of_input !== rx_want.last_of_input)
                        report_mismatch($sformatf("beat %0d last %b, want %b",
                                                  beats_seen, m_last_of_input,
                                                  rx_want.last_of_input));
                end
                beats_seen++;
                if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 5);
            end
            if (rx_stall != 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("rle_bitpack_hybrid_decoder test failed");
        $finish;
    end

    initial begin
        logic [5:0]  widths[N_PHASES];
        int unsigned phase_start;
        width_reg = 6'd1;
        clear_decoder();
        directed_rows = '{
            // empty packed run at reset width
            '{ROW_BYTE, 8'h01, 1'b1, one_result('0, '0, 1'b0, rbh_pkg::ERR_EMPTY_PACK)},
            // one group of eight single-bit values
            '{ROW_BYTE, 8'h03, 1'b0, '0},
            '{ROW_BYTE, 8'hA5, 1'b0, '0},
            // header still continuing on its fifth byte
            '{ROW_BYTE, 8'h80, 1'b0, '0},
            '{ROW_BYTE, 8'h80, 1'b0, '0},
            '{ROW_BYTE, 8'h80, 1'b0, '0},
            '{ROW_BYTE, 8'h80, 1'b0, '0},
            '{ROW_BYTE, 8'h80, 1'b1, one_result('0, '0, 1'b0, rbh_pkg::ERR_VARINT)},
            // group count right at the limit
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'h01, 1'b1, one_result('0, '0, 1'b0, rbh_pkg::ERR_GROUPS)},
            // zero repeat count swallows its value byte silently
            '{ROW_BYTE, 8'h00, 1'b0, '0},
            '{ROW_BYTE, 8'h55, 1'b0, '0},
            // repeat run of five, value masked to one bit
            '{ROW_BYTE, 8'h0A, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b1, one_result(32'd1, 32'd5, 1'b1, rbh_pkg::ERR_NONE)},
            // 34-bit repeat count saturates
            '{ROW_BYTE, 8'hFE, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'hFF, 1'b0, '0},
            '{ROW_BYTE, 8'h7F, 1'b0, '0},
            '{ROW_BYTE, 8'h80, 1'b1,
              one_result('0, 32'hFFFF_FFFF, 1'b1, rbh_pkg::ERR_NONE)},
            // oversize width saturates to 32: four value bytes
            '{ROW_CFG, 8'd63, 1'b0, '0},
            '{ROW_BYTE, 8'h02, 1'b0, '0},
            '{ROW_BYTE, 8'hEF, 1'b0, '0},
            '{ROW_BYTE, 8'hBE, 1'b0, '0},
            '{ROW_BYTE, 8'hAD, 1'b0, '0},
            '{ROW_BYTE, 8'hDE, 1'b1,
              one_result(32'hDEAD_BEEF, 32'd1, 1'b1, rbh_pkg::ERR_NONE)}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_width(directed_rows[i].data[5:0]);
            else
                send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].exp);
        end

        // Random runs, one width per phase; each width change first waits for every expected beat to drain
        widths = '{6'd1, 6'd32, 6'd0, 6'd63, 6'($urandom_range(2, 7)),
                   6'($urandom_range(9, 31)), 6'($urandom_range(0, 63)), 6'd8};
        foreach (widths[p]) begin
            write_width(widths[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / N_PHASES) send_run();
        end

        wait_idle();
        if (mismatches == 0)
            $display("rle_bitpack_hybrid_decoder test passed");
        else
            $display("rle_bitpack_hybrid_decoder test failed");
        $finish;
    end

endmodule

/* rle_bitpack_hybrid_decoder.f */
src/rbh_pkg.sv
src/rbh_parser.sv
src/rbh_unpack.sv
src/rbh_skid.sv
src/rle_bitpack_hybrid_decoder.sv
tb/sv/tb_top.sv
